// File: rtl/sphe_pkg.sv
// sphe_pkg: shared types, codes and constants of the substring hash engine.
// No dependencies; imported by every module of the block.
package sphe_pkg;

    localparam int MAX_LEN_DEF = 4096;
    localparam int VAL_W       = 31;
    localparam int IDX_W       = 12;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int STEP_W      = 6;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_MOD_A = 2'd1;
    localparam logic [1:0] REG_MOD_B = 2'd2;

    localparam logic [VAL_W-1:0] BASE_RST  = 31'd333;
    localparam logic [VAL_W-1:0] MOD_A_RST = 31'd1000000007;
    localparam logic [VAL_W-1:0] MOD_B_RST = 31'd1000003777;

    localparam logic [1:0] RD_APPEND = 2'd0;
    localparam logic [1:0] RD_RIGHT  = 2'd1;
    localparam logic [1:0] RD_LEFT   = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] left_index;
        logic [IDX_W-1:0] right_index;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] hash_a;
        logic [VAL_W-1:0] hash_b;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic       load_item;
        logic [1:0] rd_sel;
        logic       cap_op;
        logic       mul1;
        logic       mul2;
        logic       red_start;
        logic       save_y;
        logic       mem_wr;
        logic       len_inc;
        logic       len_clr;
        logic       out_load;
        logic       out_hash;
        logic [1:0] out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_append;
        logic is_query;
        logic is_clear;
        logic full;
        logic empty_range;
        logic beyond;
        logic red_done;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/sphe_modred.sv
// sphe_modred: bit-serial restoring reduction of a 62-bit value by a modulus.
// Uses sphe_pkg; one quotient bit per cycle.
module sphe_modred (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sphe_pkg::PROD_W-1:0]  value,
    input  logic [sphe_pkg::VAL_W:0]     modulus,
    output logic [sphe_pkg::VAL_W-1:0]   res,
    output logic                         done
);
    import sphe_pkg::*;

    logic [PROD_W-1:0] val_reg;
    logic [VAL_W:0]    rem_reg;
    logic [VAL_W:0]    rem_next;
    logic [VAL_W+1:0]  shifted;
    logic [STEP_W-1:0] cnt_reg;

    assign shifted = {rem_reg, val_reg[PROD_W-1]};

    always_comb
    begin
        if (shifted >= {1'b0, modulus})
        begin
            rem_next = VAL_W'(1) == 0 ? '0 : (VAL_W+1)'(shifted - {1'b0, modulus});
        end
        else
        begin
            rem_next = (VAL_W+1)'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= STEP_W'(PROD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            val_reg <= {val_reg[PROD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = (cnt_reg == '0);
    assign res  = rem_reg[VAL_W-1:0];

endmodule

// File: rtl/sphe_lane.sv
// sphe_lane: one hash lane: prefix and power memories, shared multiplier,
// reducer and final subtraction. Uses sphe_pkg and sphe_modred.
module sphe_lane #(
    parameter int MAX_LEN = sphe_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sphe_pkg::ctrl_cmd_t           cmd,
    input  logic                          is_append,
    input  logic                          first,
    input  logic                          has_before,
    input  logic [sphe_pkg::VAL_W-1:0]    base,
    input  logic [sphe_pkg::VAL_W-1:0]    modulus,
    input  logic [7:0]                    char_code,
    input  logic [$clog2(MAX_LEN)-1:0]    p_addr,
    input  logic [$clog2(MAX_LEN)-1:0]    w_addr,
    input  logic [$clog2(MAX_LEN)-1:0]    wr_addr,
    output logic [sphe_pkg::VAL_W-1:0]    hash,
    output logic                          done
);
    import sphe_pkg::*;

    logic [VAL_W-1:0]  prefix_mem [MAX_LEN];
    logic [VAL_W-1:0]  power_mem  [MAX_LEN];
    logic [VAL_W-1:0]  p_q_reg;
    logic [VAL_W-1:0]  w_q_reg;
    logic [VAL_W-1:0]  whole_reg;
    logic [VAL_W-1:0]  pw_reg;
    logic [VAL_W-1:0]  before_reg;
    logic [VAL_W-1:0]  y_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [VAL_W-1:0]  mx;
    logic [VAL_W-1:0]  my;
    logic [PROD_W-1:0] prod;
    logic [VAL_W:0]    m_eff;
    logic [VAL_W-1:0]  red_res;
    logic [VAL_W:0]    diff;

    // modulus register zero means 2^31
    assign m_eff = (modulus == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, modulus};

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            prefix_mem[wr_addr] <= y_reg;
            power_mem[wr_addr]  <= red_res;
        end
        p_q_reg <= prefix_mem[p_addr];
        w_q_reg <= power_mem[w_addr];
    end

    always_comb
    begin
        if (cmd.mul1)
        begin
            mx = first ? '0 : p_q_reg;
            my = base;
        end
        else
        begin
            mx = is_append ? pw_reg : before_reg;
            my = is_append ? base : pw_reg;
        end
        prod = PROD_W'(mx) * PROD_W'(my);
        if (cmd.mul1)
        begin
            prod_next = is_append ? prod + PROD_W'(char_code) : PROD_W'(whole_reg);
        end
        else
        begin
            prod_next = (is_append || has_before) ? prod : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_op)
        begin
            whole_reg <= p_q_reg;
            pw_reg    <= w_q_reg;
        end
        else if (cmd.mul1)
        begin
            if (is_append)
            begin
                pw_reg <= first ? VAL_W'(1) : w_q_reg;
            end
            else
            begin
                before_reg <= p_q_reg;
            end
        end
        if (cmd.mul1 || cmd.mul2)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.save_y)
        begin
            y_reg <= red_res;
        end
    end

    sphe_modred u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.red_start),
        .value   (prod_reg),
        .modulus (m_eff),
        .res     (red_res),
        .done    (done)
    );

    // y - x, wrapped back into [0, m)
    assign diff = (y_reg >= red_res) ? {1'b0, y_reg} - {1'b0, red_res}
                                     : {1'b0, y_reg} + m_eff - {1'b0, red_res};
    assign hash = diff[VAL_W-1:0];

endmodule

// File: rtl/sphe_dp.sv
// sphe_dp: datapath: item and length registers, address generation,
// two hash lanes and the result register. Uses sphe_pkg and sphe_lane.
module sphe_dp #(
    parameter int MAX_LEN = sphe_pkg::MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sphe_pkg::ctrl_cmd_t          cmd,
    input  sphe_pkg::item_t              item,
    input  logic [sphe_pkg::VAL_W-1:0]   base,
    input  logic [sphe_pkg::VAL_W-1:0]   mod_a,
    input  logic [sphe_pkg::VAL_W-1:0]   mod_b,
    input  logic                         result_ready,
    output sphe_pkg::dp_status_t         st,
    output sphe_pkg::result_t            result,
    output logic                         result_valid
);
    import sphe_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    item_t            item_reg;
    logic [LW-1:0]    len_reg;
    result_t          result_reg;
    logic             valid_reg;
    logic [AW-1:0]    n_m1;
    logic [AW-1:0]    p_addr;
    logic [AW-1:0]    w_addr;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] hash_a;
    logic [VAL_W-1:0] hash_b;
    logic             done_a;
    logic             done_b;
    logic             is_append;
    logic             first;
    logic             has_before;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd.len_clr)
        begin
            len_reg <= '0;
        end
        else if (cmd.len_inc)
        begin
            len_reg <= len_reg + LW'(1);
        end
    end

    assign is_append  = (item_reg.mode == MODE_APPEND);
    assign first      = (len_reg == '0);
    assign has_before = (item_reg.left_index != '0);

    assign n_m1    = AW'(len_reg - LW'(1));
    assign wr_addr = AW'(len_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_RIGHT:
            begin
                p_addr = AW'(item_reg.right_index);
                w_addr = AW'(item_reg.right_index - item_reg.left_index);
            end
            RD_LEFT:
            begin
                p_addr = AW'(item_reg.left_index - IDX_W'(1));
                w_addr = n_m1;
            end
            default:
            begin
                p_addr = n_m1;
                w_addr = n_m1;
            end
        endcase
    end

    sphe_lane #(.MAX_LEN(MAX_LEN)) u_lane_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .is_append  (is_append),
        .first      (first),
        .has_before (has_before),
        .base       (base),
        .modulus    (mod_a),
        .char_code  (item_reg.char_code),
        .p_addr     (p_addr),
        .w_addr     (w_addr),
        .wr_addr    (wr_addr),
        .hash       (hash_a),
        .done       (done_a)
    );

    sphe_lane #(.MAX_LEN(MAX_LEN)) u_lane_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .is_append  (is_append),
        .first      (first),
        .has_before (has_before),
        .base       (base),
        .modulus    (mod_b),
        .char_code  (item_reg.char_code),
        .p_addr     (p_addr),
        .w_addr     (w_addr),
        .wr_addr    (wr_addr),
        .hash       (hash_b),
        .done       (done_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.hash_a <= cmd.out_hash ? hash_a : '0;
            result_reg.hash_b <= cmd.out_hash ? hash_b : '0;
            result_reg.status <= cmd.out_status;
        end
    end

    assign st.is_append   = is_append;
    assign st.is_query    = (item_reg.mode == MODE_QUERY);
    assign st.is_clear    = (item_reg.mode == MODE_CLEAR);
    assign st.full        = (len_reg == LW'(MAX_LEN));
    assign st.empty_range = (item_reg.left_index > item_reg.right_index);
    assign st.beyond      = (CW'(item_reg.right_index) >= CW'(len_reg));
    assign st.red_done    = done_a & done_b;
    assign st.out_busy    = valid_reg;

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

// File: rtl/sphe_ctrl.sv
// sphe_ctrl: sequencer of the hash engine; issues datapath commands.
// Uses sphe_pkg.
module sphe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  sphe_pkg::dp_status_t   st,
    output sphe_pkg::ctrl_cmd_t    cmd
);
    import sphe_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_RD2    = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_RED1S  = 4'd5;
    localparam logic [3:0] S_RED1W  = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_RED2S  = 4'd8;
    localparam logic [3:0] S_RED2W  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_ready = (state_reg == S_IDLE) && !st.out_busy;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (st.is_append && st.full)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_FULL;
                    state_next     = S_IDLE;
                end
                else if (st.is_query && st.empty_range)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    state_next     = S_IDLE;
                end
                else if (st.is_query && st.beyond)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_BEYOND;
                    state_next     = S_IDLE;
                end
                else if (st.is_append || st.is_query)
                begin
                    state_next = S_RD1;
                end
                else
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.len_clr    = st.is_clear;
                    state_next     = S_IDLE;
                end
            end
            S_RD1:
            begin
                cmd.rd_sel = st.is_append ? RD_APPEND : RD_RIGHT;
                state_next = st.is_append ? S_MUL1 : S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_sel = RD_LEFT;
                cmd.cap_op = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_RED1S;
            end
            S_RED1S:
            begin
                cmd.red_start = 1'b1;
                state_next    = S_RED1W;
            end
            S_RED1W:
            begin
                if (st.red_done)
                begin
                    cmd.save_y = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_RED2S;
            end
            S_RED2S:
            begin
                cmd.red_start = 1'b1;
                state_next    = S_RED2W;
            end
            S_RED2W:
            begin
                if (st.red_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.mem_wr     = st.is_append;
                cmd.len_inc    = st.is_append;
                cmd.out_load   = 1'b1;
                cmd.out_hash   = st.is_query;
                cmd.out_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/substring_poly_hash_engine.sv
// Substring polynomial hash engine, top level: APB register file,
// sequencer and datapath. Uses sphe_pkg, sphe_ctrl and sphe_dp.
//
// Usage:
//  - item channel (item_valid/item_ready/item): one transfer per command:
//    append a byte, query the hash of [left_index, right_index], or clear.
//  - result channel (result_valid/result_ready/result): exactly one transfer
//    per item, in order: both lane hashes and a status code.
//  - APB port: hash_base at 0x0, modulus_a at 0x4, modulus_b at 0x8
//    (31 bits used). Write only while no item is in flight.
// Flow: clear, rejected and unused-mode items are answered from S_DECODE
//  straight after acceptance. Appends and queries (which also pass S_RD2) run
//  two multiply steps; each lane reduces two 62-bit values in a bit-serial
//  reducer at one bit per cycle. One item is in work at a time.
// Reset: string length zero, registers to their defaults, no result valid.
//  Stored prefixes and powers are not cleared; only written entries are read.
// Stall: a finished result is held in the output register until taken;
//  item_ready stays low while that register is full.
module substring_poly_hash_engine #(
    parameter int MAX_LEN = sphe_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sphe_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output sphe_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sphe_pkg::*;

    logic [VAL_W-1:0] base_reg;
    logic [VAL_W-1:0] mod_a_reg;
    logic [VAL_W-1:0] mod_b_reg;
    logic             cfg_wr;
    ctrl_cmd_t        cmd;
    dp_status_t       st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register file; writes outside the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RST;
            mod_a_reg <= MOD_A_RST;
            mod_b_reg <= MOD_B_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BASE:  base_reg  <= pwdata[VAL_W-1:0];
                REG_MOD_A: mod_a_reg <= pwdata[VAL_W-1:0];
                REG_MOD_B: mod_b_reg <= pwdata[VAL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE:  prdata = {1'b0, base_reg};
            REG_MOD_A: prdata = {1'b0, mod_a_reg};
            REG_MOD_B: prdata = {1'b0, mod_b_reg};
            default:   prdata = '0;
        endcase
    end

    sphe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    sphe_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .base         (base_reg),
        .mod_a        (mod_a_reg),
        .mod_b        (mod_b_reg),
        .result_ready (result_ready),
        .st           (st),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// File: rtl/sphe_checker.sv
// sphe_checker: port-level assertions for the hash engine, bound to the top.
// Uses sphe_pkg.
module sphe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input sphe_pkg::item_t    item,
    input logic               result_valid,
    input logic               result_ready,
    input sphe_pkg::result_t  result
);
    import sphe_pkg::*;

    // held result must not change while stalled
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed during stall");

    // one item in work: no new transfer while a result waits
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item ready with result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item ready right after transfer");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |=> !result_valid)
        else $error("second result without an item");

    // any non-ok status carries zero hashes
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.hash_a == '0 && result.hash_b == '0)
        else $error("nonzero hash with error status");

endmodule

bind substring_poly_hash_engine sphe_checker u_sphe_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench of substring_poly_hash_engine: random and directed
// append, query, clear and unused-mode transfers, checked against an internal hash predictor.
// Depends on sphe_pkg and the RTL of the engine.
module tb_top;
    import sphe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STR_CAP     = MAX_LEN_DEF;
    localparam int  CYCLE_LIMIT = 5000000;
    localparam int  N_RANDOM    = 900;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    substring_poly_hash_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor state: a shadow copy of registers and stores.
    logic [VAL_W-1:0] base_q;
    logic [VAL_W-1:0] mod_a_q;
    logic [VAL_W-1:0] mod_b_q;
    logic [VAL_W-1:0] pre_a [STR_CAP];
    logic [VAL_W-1:0] pre_b [STR_CAP];
    logic [VAL_W-1:0] pow_a [STR_CAP+1];
    logic [VAL_W-1:0] pow_b [STR_CAP+1];
    int unsigned      str_len;

    item_t   pending_items [$];
    result_t expected_hashes [$];
    int      error_count;
    int      cycle_count;
    bit      quiet_phase;   // no idling near the end of the run
    int      send_gap;
    int      take_gap;

    // Zero modulus register means arithmetic modulo 2^31.
    function automatic longint unsigned lane_mod(logic [VAL_W-1:0] m);
        return (m == 0) ? 64'h8000_0000 : {33'd0, m};
    endfunction

    function automatic logic [VAL_W-1:0] mul_add(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y,
                                                 logic [7:0] add, longint unsigned m);
        longint unsigned p;
        p = {33'd0, x} * {33'd0, y} + add;
        return VAL_W'(p % m);
    endfunction

    function automatic logic [VAL_W-1:0] window_hash(logic [VAL_W-1:0] whole,
                                                     logic [VAL_W-1:0] prior,
                                                     logic [VAL_W-1:0] pw, bit has_prior,
                                                     longint unsigned m);
        longint unsigned y;
        longint unsigned x;
        y = {33'd0, whole} % m;
        x = has_prior ? ({33'd0, prior} * {33'd0, pw}) % m : 0;
        return VAL_W'(y >= x ? y - x : y + m - x);
    endfunction

    // Computes the result of one item and advances the shadow state.
    function automatic result_t predict_hash(item_t it);
        result_t         r;
        longint unsigned ma;
        longint unsigned mb;
        int unsigned     n;
        int unsigned     span;
        int unsigned     li;
        bit              has_prior;
        logic [VAL_W-1:0] pa;
        logic [VAL_W-1:0] pb;
        r  = '0;
        ma = lane_mod(mod_a_q);
        mb = lane_mod(mod_b_q);
        case (it.mode)
            MODE_APPEND:
            begin
                if (str_len >= STR_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    n  = str_len;
                    pa = n ? pre_a[n-1] : '0;
                    pb = n ? pre_b[n-1] : '0;
                    pre_a[n]   = mul_add(pa, base_q, it.char_code, ma);
                    pre_b[n]   = mul_add(pb, base_q, it.char_code, mb);
                    pow_a[n+1] = mul_add(pow_a[n], base_q, 8'd0, ma);
                    pow_b[n+1] = mul_add(pow_b[n], base_q, 8'd0, mb);
                    str_len    = n + 1;
                end
            end
            MODE_QUERY:
            begin
                if (it.left_index > it.right_index) begin
                    r.status = ST_EMPTY;
                end else if (it.right_index >= str_len) begin
                    r.status = ST_BEYOND;
                end else begin
                    span      = it.right_index - it.left_index + 1;
                    has_prior = it.left_index > 0;
                    li        = has_prior ? it.left_index - 1 : 0;
                    r.hash_a  = window_hash(pre_a[it.right_index], pre_a[li], pow_a[span],
                                            has_prior, ma);
                    r.hash_b  = window_hash(pre_b[it.right_index], pre_b[li], pow_b[span],
                                            has_prior, mb);
                end
            end
            MODE_CLEAR:
            begin
                str_len = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic item_t make_item(logic [1:0] md, logic [7:0] ch,
                                        int unsigned l, int unsigned r);
        item_t it;
        it.mode        = md;
        it.char_code   = ch;
        it.left_index  = IDX_W'(l);
        it.right_index = IDX_W'(r);
        return it;
    endfunction

    // Queue an item; its expectation is formed at acceptance time by the driver.
    task automatic push_item(item_t it);
        pending_items.push_back(it);
    endtask

    // Random query kept inside the written part of the store, plus some noise.
    function automatic item_t rand_query(int unsigned len_now);
        int unsigned l;
        int unsigned r;
        if (len_now == 0 || $urandom_range(0, 9) == 0) begin
            l = $urandom_range(0, 4095);
            r = $urandom_range(0, 4095);
            // Beyond-length queries are allowed; they never read the store.
        end else begin
            r = $urandom_range(0, len_now - 1);
            l = $urandom_range(0, r);
        end
        return make_item(MODE_QUERY, 8'($urandom), l, r);
    endfunction

    // Waits until every queued item has been sent and answered, then lets the
    // block settle for the clear/rejected latency.
    task automatic drain;
        while (pending_items.size() != 0 || expected_hashes.size() != 0 || item_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE:  base_q  = val[VAL_W-1:0];
            REG_MOD_A: mod_a_q = val[VAL_W-1:0];
            default:   mod_b_q = val[VAL_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] b, logic [31:0] ma, logic [31:0] mb);
        apb_write(REG_BASE, b);
        apb_write(REG_MOD_A, ma);
        apb_write(REG_MOD_B, mb);
    endtask

    // Tracks the string length as the queue will see it, so random queries
    // are built against the state at the time they run.
    int unsigned plan_len;

    task automatic plan(item_t it);
        if (it.mode == MODE_APPEND && plan_len < STR_CAP) plan_len++;
        if (it.mode == MODE_CLEAR) plan_len = 0;
        push_item(it);
    endtask

    task automatic random_phase(int count);
        int k;
        int burst;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0:       plan(make_item(MODE_CLEAR, 8'($urandom), $urandom, $urandom));
                1:       plan(make_item(2'd3, 8'($urandom), $urandom, $urandom));
                2, 3, 4, 5, 6, 7, 8:
                    plan(rand_query(plan_len));
                default: plan(make_item(MODE_APPEND, 8'($urandom), $urandom, $urandom));
            endcase
            if (k % 50 == 0) begin
                burst = $urandom_range(0, 3);
                while (burst-- > 0) plan(rand_query(plan_len));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: presents queued items, holds valid until the transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   <= 0;
        end else begin
            if (item_valid && item_ready) begin
                expected_hashes.push_back(predict_hash(item));
            end
            if (item_valid && !item_ready) begin
                // hold
            end else if (send_gap > 0) begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (pending_items.size() != 0
                         && !(item_valid && item_ready && pending_items.size() == 0)) begin
                item_valid <= 1'b1;
                item       <= pending_items.pop_front();
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 3);
            end else begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compares each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_ready <= 1'b0;
            take_gap     <= 0;
        end else begin
            if (result_valid && result_ready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, result);
                    error_count++;
                end else begin
                    result_t e;
                    e = expected_hashes.pop_front();
                    if (e.hash_a !== result.hash_a)
                        $display("%0t: hash_a expected %h actual %h",
                                 $time, e.hash_a, result.hash_a);
                    if (e.hash_b !== result.hash_b)
                        $display("%0t: hash_b expected %h actual %h",
                                 $time, e.hash_b, result.hash_b);
                    if (e.status !== result.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, result.status);
                    if (e !== result) error_count++;
                end
            end
            if (take_gap > 0) begin
                result_ready <= 1'b0;
                take_gap     <= take_gap - 1;
            end else begin
                result_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 4) == 0)
                    take_gap <= $urandom_range(1, 3);
            end
        end
    end

    initial
    begin
        int k;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        plan_len    = 0;
        base_q      = BASE_RST;
        mod_a_q     = MOD_A_RST;
        mod_b_q     = MOD_B_RST;
        str_len     = 0;
        pow_a[0]    = 1;
        pow_b[0]    = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, every mode, field extremes, error codes.
        plan(make_item(MODE_QUERY, 8'h00, 0, 0));          // beyond length on empty
        plan(make_item(MODE_APPEND, 8'hFF, 12'hFFF, 12'hFFF));
        plan(make_item(MODE_APPEND, 8'h00, 0, 0));
        plan(make_item(MODE_APPEND, 8'hA5, 0, 0));
        plan(make_item(MODE_QUERY, 8'hFF, 0, 2));
        plan(make_item(MODE_QUERY, 8'h00, 1, 2));
        plan(make_item(MODE_QUERY, 8'h00, 2, 2));
        plan(make_item(MODE_QUERY, 8'h00, 2, 1));           // empty range
        plan(make_item(MODE_QUERY, 8'h00, 4095, 0));        // empty range, left index at its maximum
        plan(make_item(MODE_QUERY, 8'h00, 0, 4095));        // beyond length
        plan(make_item(2'd3, 8'hFF, 12'hFFF, 12'hFFF));     // unused mode
        plan(make_item(MODE_CLEAR, 8'hFF, 12'hFFF, 12'hFFF));
        plan(make_item(MODE_QUERY, 8'h00, 0, 0));
        drain();

        // Extreme register values: large base, modulus 2^31-1 on lane a, 2^31 on lane b.
        set_regs(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0);
        for (k = 0; k < 6; k++) plan(make_item(MODE_APPEND, 8'($urandom), 0, 0));
        plan(make_item(MODE_QUERY, 8'h00, 1, 5));
        plan(make_item(MODE_QUERY, 8'h00, 0, 5));
        drain();
        // Registers change with a string loaded: stored entries are re-reduced.
        set_regs(32'hFFFF_FFFF, 32'd1, 32'd2);
        plan(make_item(MODE_QUERY, 8'h00, 2, 4));
        plan(make_item(MODE_APPEND, 8'h7F, 0, 0));
        plan(make_item(MODE_QUERY, 8'h00, 0, 6));
        plan(make_item(MODE_CLEAR, 8'h00, 0, 0));
        drain();

        // Fill to capacity, then a rejected append and wide queries.
        set_regs(32'd1, 32'd97, 32'd101);
        for (k = 0; k < STR_CAP; k++) plan(make_item(MODE_APPEND, 8'($urandom), 0, 0));
        plan(make_item(MODE_APPEND, 8'h55, 0, 0));
        plan(make_item(MODE_QUERY, 8'h00, 0, 4095));
        plan(make_item(MODE_QUERY, 8'h00, 4095, 4095));
        plan(make_item(MODE_QUERY, 8'h00, 1, 4095));
        plan(make_item(MODE_CLEAR, 8'h00, 0, 0));
        drain();

        // Random phases under several register settings.
        set_regs(BASE_RST, MOD_A_RST, MOD_B_RST);
        random_phase(N_RANDOM / 3);
        drain();
        set_regs($urandom_range(1, 32'h7FFF_FFFE), $urandom_range(2, 32'h7FFF_FFFF),
                 $urandom_range(2, 32'h7FFF_FFFF));
        random_phase(N_RANDOM / 3);
        drain();
        set_regs(32'd256, 32'd65521, 32'd2147483647);
        quiet_phase = 1'b1;
        random_phase(N_RANDOM / 3);
        drain();
        repeat (200) @(posedge clk);

        if (error_count == 0 && expected_hashes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/sphe_pkg.sv
rtl/sphe_modred.sv
rtl/sphe_lane.sv
rtl/sphe_dp.sv
rtl/sphe_ctrl.sv
rtl/substring_poly_hash_engine.sv
rtl/sphe_checker.sv
tb/sv/tb_top.sv
